// ===== hw/rtl/pip_pkg.sv =====
package pip_pkg;
	localparam int MaxVerticesDefault = 64;
	localparam int CoordBitsDefault = 24;
	localparam int CountBits = 7;
	localparam int MinVertices = 3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;
endpackage

// ===== hw/rtl/point_in_polygon_test.sv =====
// channel | signals                                   | dir | word
// in      | in_valid in_ready mode vertex_index coords | in  | vertex load or query
// out     | out_valid out_ready inside_res on_edge    | out | query answer
// cfg     | cfg_valid cfg_ready cfg_data              | in  | vertex_count
// a load gives no word
// a query, from accept to answer for n vertices in use, passes n + 1 reads
// (the last rereads vertex 0) through the single read port, the registered read,
// two test stages, the count compare and the output load
// reset clears control and sets vertex_count to 3; memories are undefined until written
// the answer sits in an output register; while it waits the input is held off
module point_in_polygon_test import pip_pkg::*; #(
	parameter int MaxVertices = MaxVerticesDefault,
	parameter int CoordBits = CoordBitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [5:0]                  vertex_index,
	input  logic signed [CoordBits-1:0] coord_x,
	input  logic signed [CoordBits-1:0] coord_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        inside_res,
	output logic                        on_edge,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CountBits-1:0]        cfg_data
);
	localparam int AW = $clog2(MaxVertices);
	localparam int NW = AW + 1;

	state_t state_q, state_d;
	logic [CountBits-1:0] count_q;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] rd_q;        // read step 0..n (step n rereads vertex 0)
	logic [NW-1:0] done_q;      // edge results collected
	logic v1_q, v2_q, v3_q;     // valid along read / test pipe
	logic signed [CoordBits-1:0] px_q, py_q, prevx_q, prevy_q;
	logic signed [CoordBits-1:0] rx, ry;
	logic touch, cross_hit, on_q, odd_q;
	logic we, issue, finish;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CountBits'(MinVertices);
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	// saturate the count into 3..MaxVertices
	always_comb begin
		if ({{(32-CountBits){1'b0}}, count_q} < MinVertices) begin
			n_eff = NW'(MinVertices);
		end else if ({{(32-CountBits){1'b0}}, count_q} > MaxVertices) begin
			n_eff = NW'(MaxVertices);
		end else begin
			n_eff = NW'(count_q);
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign we = in_valid && in_ready && !mode &&
		({26'd0, vertex_index} < MaxVertices);
	assign waddr = AW'(vertex_index);
	assign issue = (state_q == ST_WALK) && (rd_q <= n_eff);
	assign raddr = (rd_q >= n_eff) ? '0 : rd_q[AW-1:0];
	assign finish = (state_q == ST_WALK) && (done_q == n_eff);

	pip_ram #(.Width(CoordBits), .Depth(MaxVertices)) u_ram_x (
		.clk, .we, .waddr, .wdata(coord_x), .raddr, .rdata(rx)
	);
	pip_ram #(.Width(CoordBits), .Depth(MaxVertices)) u_ram_y (
		.clk, .we, .waddr, .wdata(coord_y), .raddr, .rdata(ry)
	);

	pip_edge #(.CoordBits(CoordBits)) u_edge (
		.clk, .ax(prevx_q), .ay(prevy_q), .bx(rx), .by(ry), .px(px_q), .py(py_q),
		.touch_s2(touch), .cross_s2(cross_hit)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && in_ready && mode) state_d = ST_WALK;
			ST_WALK: if (finish) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_q <= '0;
			done_q <= '0;
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			on_q <= 1'b0;
			odd_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				rd_q <= '0;
				done_q <= '0;
				on_q <= 1'b0;
				odd_q <= 1'b0;
			end else begin
				if (issue) rd_q <= rd_q + 1'b1;
				// first read only primes the previous vertex
				v1_q <= issue && (rd_q != '0);
				v2_q <= v1_q;
				v3_q <= v2_q;
				if (v3_q) begin
					done_q <= done_q + 1'b1;
					on_q <= on_q | touch;
					odd_q <= odd_q ^ cross_hit;
				end
			end
			if (state_q == ST_DONE) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && mode) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		// keep the edge start: memory output from the previous read
		if (state_q == ST_WALK) begin
			prevx_q <= rx;
			prevy_q <= ry;
		end
		if (state_q == ST_DONE) begin
			inside_res <= on_q | odd_q;
			on_edge <= on_q;
		end
	end
endmodule

// ===== hw/rtl/pip_ram.sv =====
module pip_ram #(
	parameter int Width = 24,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/pip_edge.sv =====
// one edge test per cycle: on-edge check and half-open crossing check
module pip_edge import pip_pkg::*; #(
	parameter int CoordBits = 24
) (
	input  logic                        clk,
	input  logic signed [CoordBits-1:0] ax,
	input  logic signed [CoordBits-1:0] ay,
	input  logic signed [CoordBits-1:0] bx,
	input  logic signed [CoordBits-1:0] by,
	input  logic signed [CoordBits-1:0] px,
	input  logic signed [CoordBits-1:0] py,
	output logic                        touch_s2,
	output logic                        cross_s2
);
	localparam int DW = CoordBits + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] dxb, dyb, dxp, dyp;
	logic signed [PW-1:0] p1_s1, p2_s1, p3_s1, p4_s1;
	logic                 box_s1, straddle_s1, dypos_s1;

	always_comb begin
		dxb = DW'(bx) - DW'(ax);
		dyb = DW'(by) - DW'(ay);
		dxp = DW'(px) - DW'(ax);
		dyp = DW'(py) - DW'(ay);
	end

	always_ff @(posedge clk) begin
		p1_s1 <= PW'(dxb) * PW'(dyp);
		p2_s1 <= PW'(dyb) * PW'(dxp);
		p3_s1 <= PW'(dxp) * PW'(dyb);
		p4_s1 <= PW'(dyp) * PW'(dxb);
		box_s1 <= ((px >= ax && px <= bx) || (px >= bx && px <= ax)) &&
			((py >= ay && py <= by) || (py >= by && py <= ay));
		straddle_s1 <= (ay > py) != (by > py);
		dypos_s1 <= dyb > 0;
	end

	always_ff @(posedge clk) begin
		touch_s2 <= box_s1 && (p1_s1 == p2_s1);
		// crossing strictly right: (x-ax)*dy vs (y-ay)*dx, sign follows dy
		cross_s2 <= straddle_s1 && (dypos_s1 ? (p3_s1 < p4_s1) : (p3_s1 > p4_s1));
	end
endmodule

// ===== test/point_in_polygon_test_test.sv =====
module point_in_polygon_test_test;
	import pip_pkg::*;

	localparam int CoordBits = CoordBitsDefault;
	localparam int MaxVert = MaxVerticesDefault;
	localparam bit MODE_LOAD = 1'b0;
	localparam bit MODE_QUERY = 1'b1;
	localparam longint CoordMin = -(64'sd1 <<< (CoordBits - 1));
	localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;
	localparam int CycleLimit = 1000000;
	localparam int SettleCycles = MaxVert + 16;
	localparam int HoldCycles = 600;

	// scoreboard: mirrors the vertex stores and the count register,
	// and predicts the answer word for every accepted query
	class polygon_board;
		longint vx[MaxVert];
		longint vy[MaxVert];
		int unsigned count_reg;
		bit [1:0] answers[$];
		int errors;

		function new();
			count_reg = MinVertices;
			errors = 0;
		endfunction

		function void set_count(int unsigned value);
			count_reg = value;
		endfunction

		function int pending();
			return answers.size();
		endfunction

		function bit on_segment(longint ax, longint ay, longint bx, longint by,
				longint x, longint y);
			longint area2;
			area2 = (bx - ax) * (y - ay) - (by - ay) * (x - ax);
			if (area2 != 0)
				return 1'b0;
			return x >= (ax < bx ? ax : bx) && x <= (ax < bx ? bx : ax) &&
				y >= (ay < by ? ay : by) && y <= (ay < by ? by : ay);
		endfunction

		// returns {inside, on_edge}
		function bit [1:0] classify(longint x, longint y);
			int unsigned n;
			int w;
			bit odd;
			longint dy, s;
			n = count_reg < MinVertices ? MinVertices : count_reg;
			if (n > MaxVert)
				n = MaxVert;
			for (int v = 0; v < n; v++) begin
				w = (v + 1 == n) ? 0 : v + 1;
				if (on_segment(vx[v], vy[v], vx[w], vy[w], x, y))
					return 2'b11;
			end
			odd = 1'b0;
			for (int v = 0; v < n; v++) begin
				w = (v + 1 == n) ? 0 : v + 1;
				// half-open rule: exactly one end strictly above the ray
				if ((vy[v] > y) != (vy[w] > y)) begin
					dy = vy[w] - vy[v];
					s = (x - vx[v]) * dy - (y - vy[v]) * (vx[w] - vx[v]);
					if (dy > 0 ? (s < 0) : (s > 0))
						odd = !odd;
				end
			end
			return {odd, 1'b0};
		endfunction

		function void note_word(bit m, bit [5:0] idx, longint x, longint y);
			if (m == MODE_LOAD) begin
				vx[idx] = x;
				vy[idx] = y;
			end else
				answers.push_back(classify(x, y));
		endfunction

		function void check_word(bit ins, bit edge_hit);
			bit [1:0] want;
			if (answers.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected answer inside=%0b on_edge=%0b", ins, edge_hit);
				return;
			end
			want = answers.pop_front();
			if (want != {ins, edge_hit}) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected inside=%0b on_edge=%0b, got %0b %0b",
						want[1], want[0], ins, edge_hit);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [5:0] vertex_index = '0;
	logic signed [CoordBits-1:0] coord_x = '0;
	logic signed [CoordBits-1:0] coord_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic inside_res;
	logic on_edge;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CountBits-1:0] cfg_data = '0;

	polygon_board board = new();
	int cycles = 0;
	bit hold_request = 1'b0;

	// current polygon, used to aim queries at interesting spots
	longint poly_x[MaxVert];
	longint poly_y[MaxVert];
	int poly_n = MinVertices;

	point_in_polygon_test uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.vertex_index(vertex_index), .coord_x(coord_x), .coord_y(coord_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.inside_res(inside_res), .on_edge(on_edge),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("FAIL point_in_polygon_test");
			$finish;
		end
	end

	// answer monitor, samples pre-edge values
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_word(inside_res, on_edge);
	end

	// receiver back-pressure: random runs of ready and stall, plus one long hold
	initial begin
		int run_left;
		bit level;
		run_left = 0;
		level = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_request = 1'b0;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					level = ($urandom_range(0, 3) != 0);
					if ($urandom_range(0, 9) == 0)
						run_left = $urandom_range(20, 60);
					else
						run_left = $urandom_range(1, 4);
				end
				out_ready <= level;
				run_left--;
			end
		end
	end

	function automatic longint clamp(longint v);
		if (v < CoordMin)
			return CoordMin;
		if (v > CoordMax)
			return CoordMax;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 19)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic longint full_coord();
		return clamp(longint'($signed($urandom_range(0, (1 << CoordBits) - 1) << 8)) >>> 8);
	endfunction

	// offer one word and wait for it to be taken; valid stays up across back-to-back words
	task automatic send_word(bit m, bit [5:0] idx, longint x, longint y, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		vertex_index <= idx;
		coord_x <= x[CoordBits-1:0];
		coord_y <= y[CoordBits-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		board.note_word(m, idx, x, y);
	endtask

	task automatic load_vertex(int idx, longint x, longint y);
		if (idx < MaxVert) begin
			poly_x[idx] = x;
			poly_y[idx] = y;
		end
		send_word(MODE_LOAD, idx[5:0], x, y, pick_gap());
	endtask

	task automatic query(longint x, longint y);
		send_word(MODE_QUERY, 6'($urandom()), x, y, pick_gap());
	endtask

	// drop valid, drain all answers, let any walk finish, then write the count
	task automatic write_count(int unsigned value);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value[CountBits-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_count(value);
		poly_n = value < MinVertices ? MinVertices : (value > MaxVert ? MaxVert : value);
	endtask

	// random polygon around a center: star shape, sometimes repeated or wild vertices
	task automatic load_polygon();
		longint cx, cy, rad, r;
		real ang;
		int shape;
		shape = $urandom_range(0, 3);
		rad = (shape == 0) ? $urandom_range(2000000, 8000000) : $urandom_range(4, 2000);
		cx = (shape == 0) ? 0 : $signed($urandom_range(0, 2000)) - 1000;
		cy = (shape == 0) ? 0 : $signed($urandom_range(0, 2000)) - 1000;
		for (int k = 0; k < poly_n; k++) begin
			ang = 6.283185307 * k / poly_n;
			r = $urandom_range(rad / 2, rad);
			if (k > 0 && $urandom_range(0, 9) == 0)
				load_vertex(k, poly_x[k-1], poly_y[k-1]);
			else if (shape == 3 && $urandom_range(0, 3) == 0)
				load_vertex(k, cx + $signed($urandom_range(0, 2 * rad)) - rad,
					cy + $signed($urandom_range(0, 2 * rad)) - rad);
			else
				load_vertex(k, clamp(cx + $rtoi(r * $cos(ang))),
					clamp(cy + $rtoi(r * $sin(ang))));
		end
	endtask

	// aim a query at a vertex, an edge, a vertex row, near points, anywhere, or the mean of three vertices
	task automatic random_query();
		int a, b;
		longint x, y;
		a = $urandom_range(0, poly_n - 1);
		b = (a + 1 == poly_n) ? 0 : a + 1;
		case ($urandom_range(0, 7))
			0: begin
				x = poly_x[a];
				y = poly_y[a];
			end
			1: begin
				x = (poly_x[a] + poly_x[b]) >>> 1;
				y = (poly_y[a] + poly_y[b]) >>> 1;
			end
			2: begin
				x = poly_x[b] + $signed($urandom_range(0, 4)) - 2;
				y = poly_y[a];
			end
			3: begin
				x = poly_x[a] + $signed($urandom_range(0, 2)) - 1;
				y = poly_y[a] + $signed($urandom_range(0, 2)) - 1;
			end
			4: begin
				x = full_coord();
				y = full_coord();
			end
			default: begin
				x = (poly_x[a] + poly_x[b] + poly_x[$urandom_range(0, poly_n - 1)]) / 3;
				y = (poly_y[a] + poly_y[b] + poly_y[$urandom_range(0, poly_n - 1)]) / 3;
			end
		endcase
		query(clamp(x), clamp(y));
	endtask

	initial begin
		int unsigned counts[$];
		counts = '{1, 127, 64, 63, 2, 8, 16, 5, 32, 0, 64};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every slot gets written first, so no query ever reads an empty slot
		for (int k = 0; k < MaxVert; k++)
			load_vertex(k, full_coord(), full_coord());

		// reset count of three: small triangle, a corner, edges, inside, outside
		load_vertex(0, 0, 0);
		load_vertex(1, 100, 0);
		load_vertex(2, 0, 100);
		query(0, 0);
		query(50, 0);
		query(50, 50);
		query(0, 50);
		query(10, 10);
		query(60, 60);
		query(101, 0);
		query(-1, 50);
		query(CoordMin, CoordMin);
		query(CoordMax, CoordMax);

		// full-range square with a degenerate edge repeated onto the last corner
		write_count(5);
		load_vertex(0, CoordMin, CoordMin);
		load_vertex(1, CoordMax, CoordMin);
		load_vertex(2, CoordMax, CoordMax);
		load_vertex(3, CoordMin, CoordMax);
		load_vertex(4, CoordMin, CoordMax);
		query(CoordMax, CoordMax);
		query(0, CoordMin);
		query(CoordMin, 0);
		query(0, 0);
		query(CoordMax - 1, CoordMax - 1);
		// a load to the top slot must not disturb the square
		load_vertex(63, 7, -7);
		query(1, 1);

		// long output stall while the sender keeps offering queries
		hold_request = 1'b1;
		repeat (12) random_query();

		foreach (counts[p]) begin
			write_count(p == counts.size() - 1 ? $urandom_range(0, 127) : counts[p]);
			load_polygon();
			repeat (75) begin
				if ($urandom_range(0, 9) == 0)
					load_vertex($urandom_range(0, poly_n - 1),
						poly_x[$urandom_range(0, poly_n - 1)] + $signed($urandom_range(0, 8)) - 4,
						poly_y[$urandom_range(0, poly_n - 1)]);
				else
					random_query();
			end
		end

		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (board.errors == 0)
			$display("PASS point_in_polygon_test");
		else
			$display("FAIL point_in_polygon_test");
		$finish;
	end
endmodule
